// File: design/xxtea_pkg.sv
`timescale 1ns / 1ps

package xxtea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;
  localparam int          KEY_WORDS = 4;
  localparam int          NW        = 7;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  rounds_t;

  // 6 + 52/n for n = 2..64
  function automatic rounds_t xxt_rounds(input logic [NW-1:0] n);
    rounds_t r;
    r = 6'd6;
    if (n <= 7'd2) begin
      r = 6'd32;
    end else if (n == 7'd3) begin
      r = 6'd23;
    end else if (n == 7'd4) begin
      r = 6'd19;
    end else if (n == 7'd5) begin
      r = 6'd16;
    end else if (n == 7'd6) begin
      r = 6'd14;
    end else if (n == 7'd7) begin
      r = 6'd13;
    end else if (n == 7'd8) begin
      r = 6'd12;
    end else if (n <= 7'd10) begin
      r = 6'd11;
    end else if (n <= 7'd13) begin
      r = 6'd10;
    end else if (n <= 7'd17) begin
      r = 6'd9;
    end else if (n <= 7'd26) begin
      r = 6'd8;
    end else if (n <= 7'd52) begin
      r = 6'd7;
    end
    return r;
  endfunction

  function automatic word_t xxt_mix(input word_t y, input word_t z, input word_t sum,
                                    input word_t k);
    word_t a;
    word_t b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (k ^ z);
    return a ^ b;
  endfunction

endpackage

// File: design/xxtea_block_cipher_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready   | in_op, in_data_word, in_is_last
// out     | out | out_valid / out_ready | out_result_word, out_result_last, out_overflow
// cfg     | in  | cfg_we                | cfg_index (key word), cfg_wdata
//
// Words are taken one per cycle while idle; the closing word starts the run.
// Setup runs through S_PREP and S_SUM, then each mixing step runs through S_MIX
// and S_UPD on the single mix/add unit and block store port, for 6+52/n rounds.
// Results leave one word at a time, each loaded in S_OLD and held in S_OUT until taken.
// in_ready is low from the closing word until the last result is taken.
// Reset (synchronous, rst_n low) clears the key, word count, overflow flag and handshake state.

module xxtea_block_cipher_top
  import xxtea_pkg::*;
#(
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_data_word,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_word,
  output logic        out_result_last,
  output logic        out_overflow
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SUM, S_MIX, S_UPD, S_ORD, S_OLD, S_OUT
  } state_t;

  state_t          state_r;
  word_t           key_r [KEY_WORDS];
  word_t           mem [MAX_WORDS];
  word_t           rdata_r;
  word_t           fwd_data_r;
  logic            fwd_r;
  logic [CW-1:0]   count_r;
  logic            ovf_r;
  logic            op_r;
  word_t           first_r;
  word_t           recent_r;
  word_t           x_r;
  word_t           prev_r;
  word_t           nb_r;
  word_t           mix_r;
  word_t           sum_r;
  rounds_t         rnd_r;
  logic [AW-1:0]   p_r;
  logic [AW-1:0]   o_r;
  word_t           out_word_r;
  logic            out_last_r;
  logic            out_valid_r;

  logic            in_fire;
  logic            out_fire;
  logic            store_ok;
  logic [AW-1:0]   last_idx;
  logic [AW-1:0]   p_step;
  logic [AW-1:0]   pn_step;
  logic            round_end;
  word_t           rd;
  word_t           mix_y;
  word_t           mix_z;
  word_t           upd_val;
  logic [1:0]      key_sel;
  logic            we;
  logic [AW-1:0]   wa;
  word_t           wd;
  logic [AW-1:0]   ra;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_fire        = out_valid_r && out_ready;
  assign out_result_word = out_word_r;
  assign out_result_last = out_last_r;
  assign out_overflow    = ovf_r;

  assign store_ok  = (count_r < CW'(MAX_WORDS));
  assign last_idx  = AW'(count_r - CW'(1));
  assign rd        = fwd_r ? fwd_data_r : rdata_r;

  always_comb begin
    if (op_r) begin
      p_step    = (p_r == '0) ? last_idx : p_r - AW'(1);
      pn_step   = (p_step == '0) ? last_idx : p_step - AW'(1);
      round_end = (p_r == '0);
      mix_y     = prev_r;
      mix_z     = rd;
      upd_val   = x_r - mix_r;
    end else begin
      p_step    = (p_r == last_idx) ? '0 : p_r + AW'(1);
      pn_step   = (p_step == last_idx) ? '0 : p_step + AW'(1);
      round_end = (p_r == last_idx);
      mix_y     = rd;
      mix_z     = prev_r;
      upd_val   = x_r + mix_r;
    end
  end

  assign key_sel = 2'(p_r) ^ sum_r[3:2];

  always_comb begin
    we = 1'b0;
    wa = p_r;
    wd = upd_val;
    ra = o_r;
    case (state_r)
      S_IDLE: begin
        we = in_fire && store_ok;
        wa = AW'(count_r);
        wd = in_data_word;
      end
      S_SUM:   ra = p_step;
      S_UPD: begin
        we = 1'b1;
        ra = pn_step;
      end
      S_OUT:   ra = o_r + AW'(1);
      default: ra = o_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r    <= mem[ra];
    fwd_r      <= we && (ra == wa);
    fwd_data_r <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (store_ok) begin
              count_r  <= count_r + CW'(1);
              recent_r <= in_data_word;
              if (count_r == '0) begin
                first_r <= in_data_word;
              end
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_is_last) begin
              op_r    <= in_op;
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          rnd_r <= xxt_rounds(NW'(count_r));
          o_r   <= '0;
          if (op_r) begin
            p_r    <= last_idx;
            x_r    <= recent_r;
            prev_r <= first_r;
          end else begin
            p_r    <= '0;
            x_r    <= first_r;
            prev_r <= recent_r;
          end
          state_r <= (count_r == CW'(1)) ? S_ORD : S_SUM;
        end
        S_SUM: begin
          sum_r   <= op_r ? 32'({26'd0, rnd_r} * TEA_DELTA) : TEA_DELTA;
          state_r <= S_MIX;
        end
        S_MIX: begin
          mix_r   <= xxt_mix(mix_y, mix_z, sum_r, key_r[key_sel]);
          nb_r    <= rd;
          state_r <= S_UPD;
        end
        S_UPD: begin
          prev_r  <= upd_val;
          x_r     <= nb_r;
          p_r     <= p_step;
          state_r <= S_MIX;
          if (round_end) begin
            sum_r <= op_r ? sum_r - TEA_DELTA : sum_r + TEA_DELTA;
            rnd_r <= rnd_r - 6'd1;
            if (rnd_r == 6'd1) begin
              state_r <= S_ORD;
            end
          end
        end
        S_ORD: begin
          state_r <= S_OLD;
        end
        S_OLD: begin
          out_word_r  <= rdata_r;
          out_last_r  <= (o_r == last_idx);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              o_r     <= o_r + AW'(1);
              state_r <= S_OLD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_last) |=> !in_ready)
    else $error("block not closed after last word");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_result_last) |=> (in_ready && count_r == '0 && !ovf_r))
    else $error("block state not cleared after last result");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_WORDS))
    else $error("word count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (count_r == CW'(MAX_WORDS)))
    else $error("overflow flagged before store full");

endmodule
